@@ rtl/biquad_iir_section_macros.svh @@
// Assertion macros for the biquad section. Define ASSERT_OFF to drop them.
// Every macro expects signals named clk and arst_n in the using module.
`ifndef BIQUAD_IIR_SECTION_MACROS_SVH
`define BIQUAD_IIR_SECTION_MACROS_SVH

`ifndef ASSERT_OFF
`define BIQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BIQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BIQ_ASSERT(lbl, prop, msg)
`define BIQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/biq_pkg.sv @@
package biq_pkg;

	localparam int SAMPLE_BITS_DEF    = 24;
	localparam int COEF_FRAC_BITS_DEF = 29;
	localparam int COEF_BITS          = 32;
	localparam int ACC_BITS           = 48;
	localparam int SUM_BITS           = 64;
	localparam int NUM_REGS           = 6;
	localparam int REG_IDX_BITS       = $clog2(NUM_REGS);

	// b0 resets to 1.0 in Q3.29
	localparam logic signed [COEF_BITS-1:0] B0_RESET = 32'sd536870912;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2,
		REG_FORM
	} reg_idx_t;

	localparam logic FORM_DF1  = 1'b0;
	localparam logic FORM_TDF2 = 1'b1;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] b0;
		logic signed [COEF_BITS-1:0] b1;
		logic signed [COEF_BITS-1:0] b2;
		logic signed [COEF_BITS-1:0] a1;
		logic signed [COEF_BITS-1:0] a2;
		logic                        form;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_S1,
		ST_S2,
		ST_S3,
		ST_S4,
		ST_S5
	} state_t;

	// en: execute the step named by step in this cycle
	typedef struct packed {
		logic   en;
		state_t step;
	} cmd_t;

	// clamp a wide sum to the signed accumulator range
	function automatic logic signed [ACC_BITS-1:0] sat_acc(
		input logic signed [SUM_BITS-1:0] v
	);
		logic signed [SUM_BITS-1:0] hi;
		logic signed [SUM_BITS-1:0] lo;
		logic signed [ACC_BITS-1:0] r;
		hi = SUM_BITS'({1'b0, {(ACC_BITS-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			r = hi[ACC_BITS-1:0];
		end else if (v < lo) begin
			r = lo[ACC_BITS-1:0];
		end else begin
			r = v[ACC_BITS-1:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/biq_in_if.sv @@
interface biq_in_if #(
	parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          restart;

	modport source (output valid, output sample, output restart, input ready);
	modport sink   (input valid, input sample, input restart, output ready);
endinterface

@@ rtl/biq_out_if.sv @@
interface biq_out_if #(
	parameter int SAMPLE_BITS = biq_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filtered;
	logic                          clipped;

	modport source (output valid, output filtered, output clipped, input ready);
	modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

@@ rtl/biq_cfg.sv @@
module biq_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              we,
	input  logic [biq_pkg::REG_IDX_BITS-1:0]  index,
	input  logic [biq_pkg::COEF_BITS-1:0]     data,
	output biq_pkg::cfg_t                     cfg
);
	import biq_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.b0   <= B0_RESET;
			cfg_q.b1   <= '0;
			cfg_q.b2   <= '0;
			cfg_q.a1   <= '0;
			cfg_q.a2   <= '0;
			cfg_q.form <= FORM_DF1;
		end else if (we) begin
			unique case (reg_idx_t'(index))
				REG_B0:   cfg_q.b0   <= data;
				REG_B1:   cfg_q.b1   <= data;
				REG_B2:   cfg_q.b2   <= data;
				REG_A1:   cfg_q.a1   <= data;
				REG_A2:   cfg_q.a2   <= data;
				REG_FORM: cfg_q.form <= data[0];
				default: begin
					// no register there: drop the write
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/biq_ctrl.sv @@
`include "biquad_iir_section_macros.svh"

module biq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output biq_pkg::cmd_t cmd
);
	import biq_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   last_full;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd.en   = 1'b0;
		cmd.step = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.en   = in_valid;
				if (in_valid) begin
					state_d = ST_S1;
				end
			end
			ST_S1: begin
				cmd.en  = 1'b1;
				state_d = ST_S2;
			end
			ST_S2: begin
				cmd.en  = 1'b1;
				state_d = ST_S3;
			end
			ST_S3: begin
				cmd.en  = 1'b1;
				state_d = ST_S4;
			end
			ST_S4: begin
				cmd.en  = 1'b1;
				state_d = ST_S5;
			end
			ST_S5: begin
				// hold the last step until the output register can take the word
				cmd.en = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_S5 && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// last step reached while the previous word still sits in the output register
	assign last_full = (state_q == ST_S5) && out_valid_q;

	`BIQ_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, state_q == ST_S1, "accept ignored")
	`BIQ_ASSERT(a_valid_from_last, $rose(out_valid_q) |-> $past(state_q == ST_S5), "stray valid")
	`BIQ_ASSERT_NEXT(a_hold_when_full, last_full && !out_ready, last_full, "word overrun")

endmodule

@@ rtl/biq_datapath.sv @@
module biq_datapath #(
	parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  biq_pkg::cmd_t                 cmd,
	input  biq_pkg::cfg_t                 cfg,
	input  logic signed [SAMPLE_BITS-1:0] in_sample,
	input  logic                          in_restart,
	output logic signed [SAMPLE_BITS-1:0] filtered,
	output logic                          clipped
);
	import biq_pkg::*;

	localparam int SB        = SAMPLE_BITS;
	localparam int PROD_W    = COEF_BITS + SB;
	localparam int ACC_ROOM  = ACC_BITS - SB - 3;
	localparam int ACC_FRAC  = (COEF_FRAC_BITS < ACC_ROOM) ? COEF_FRAC_BITS : ACC_ROOM;
	localparam int DROP      = COEF_FRAC_BITS - ACC_FRAC;
	localparam logic signed [SUM_BITS-1:0] RND_F = SUM_BITS'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [SUM_BITS-1:0] RND_D = (SUM_BITS'(1) << DROP) >> 1;
	localparam logic signed [SUM_BITS-1:0] Y_MAX = (SUM_BITS'(1) << (SB - 1)) - SUM_BITS'(1);
	localparam logic signed [SUM_BITS-1:0] Y_MIN = ~Y_MAX;

	logic signed [SB-1:0]        x_q;
	logic signed [SUM_BITS-1:0]  acc_q;
	logic signed [SUM_BITS-1:0]  prod_q;
	logic signed [SB-1:0]        y_q;
	logic                        clip_q;
	logic signed [ACC_BITS-1:0]  d1_q;
	logic signed [ACC_BITS-1:0]  d2_q;
	logic signed [SB-1:0]        y1_q;
	logic signed [SB-1:0]        y2_q;
	logic signed [SB-1:0]        filtered_q;
	logic                        clipped_q;

	logic                        tdf2;
	logic signed [SB-1:0]        x1;
	logic signed [SB-1:0]        x2;
	logic signed [COEF_BITS-1:0] mult_coef;
	logic signed [SB-1:0]        mult_opd;
	logic signed [PROD_W-1:0]    mult_p;
	logic                        acc_sub;
	logic signed [SUM_BITS-1:0]  acc_op;
	logic signed [SUM_BITS-1:0]  y_shr;
	logic signed [SB-1:0]        y_sat;
	logic                        y_clip;
	logic signed [SUM_BITS-1:0]  acc_in;
	logic signed [ACC_BITS-1:0]  acc_sat;
	logic signed [SUM_BITS-1:0]  pre_tdf2;

	assign tdf2 = (cfg.form == FORM_TDF2);
	// direct form 1 sees the delay registers through their sample-wide low bits
	assign x1   = $signed(d1_q[SB-1:0]);
	assign x2   = $signed(d2_q[SB-1:0]);

	// coefficient and operand for the shared multiplier
	always_comb begin
		mult_coef = cfg.b0;
		mult_opd  = x_q;
		unique case (cmd.step)
			ST_IDLE: begin
				mult_coef = cfg.b0;
				mult_opd  = in_sample;
			end
			ST_S1: begin
				mult_coef = cfg.b1;
				mult_opd  = tdf2 ? x_q : x1;
			end
			ST_S2: begin
				mult_coef = tdf2 ? cfg.a1 : cfg.b2;
				mult_opd  = tdf2 ? y_q : x2;
			end
			ST_S3: begin
				mult_coef = tdf2 ? cfg.b2 : cfg.a1;
				mult_opd  = tdf2 ? x_q : y1_q;
			end
			ST_S4: begin
				mult_coef = cfg.a2;
				mult_opd  = tdf2 ? y_q : y2_q;
			end
			default: begin
				mult_coef = cfg.b0;
				mult_opd  = x_q;
			end
		endcase
	end

	assign mult_p = mult_coef * mult_opd;

	// feedback terms are subtracted
	assign acc_sub = tdf2 ? (cmd.step == ST_S3 || cmd.step == ST_S5)
	                      : (cmd.step == ST_S4 || cmd.step == ST_S5);
	assign acc_op  = acc_sub ? (acc_q - prod_q) : (acc_q + prod_q);

	// rounding offset is already in the accumulator
	assign y_shr  = acc_op >>> COEF_FRAC_BITS;
	always_comb begin
		y_clip = 1'b1;
		if (y_shr > Y_MAX) begin
			y_sat = Y_MAX[SB-1:0];
		end else if (y_shr < Y_MIN) begin
			y_sat = Y_MIN[SB-1:0];
		end else begin
			y_sat  = y_shr[SB-1:0];
			y_clip = 1'b0;
		end
	end

	// accumulator update for the transposed form
	assign acc_in   = (cmd.step == ST_S4) ? ((acc_q >>> DROP) + SUM_BITS'(d2_q))
	                                      : (acc_op >>> DROP);
	assign acc_sat  = sat_acc(acc_in);
	assign pre_tdf2 = (in_restart ? SUM_BITS'(0) : (SUM_BITS'(d1_q) <<< DROP)) + RND_F;

	always_ff @(posedge clk) begin
		if (cmd.en) begin
			if (cmd.step != ST_S5) begin
				prod_q <= SUM_BITS'(mult_p);
			end
			case (cmd.step)
				ST_IDLE: begin
					x_q   <= in_sample;
					acc_q <= tdf2 ? pre_tdf2 : RND_F;
				end
				ST_S1: begin
					if (tdf2) begin
						y_q    <= y_sat;
						clip_q <= y_clip;
					end else begin
						acc_q <= acc_op;
					end
				end
				ST_S2, ST_S4: begin
					acc_q <= tdf2 ? (prod_q + RND_D) : acc_op;
				end
				ST_S3: begin
					acc_q <= acc_op;
				end
				ST_S5: begin
					filtered_q <= tdf2 ? y_q : y_sat;
					clipped_q  <= tdf2 ? clip_q : y_clip;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d1_q <= '0;
			d2_q <= '0;
			y1_q <= '0;
			y2_q <= '0;
		end else if (cmd.en) begin
			case (cmd.step)
				ST_IDLE: begin
					if (in_restart) begin
						d1_q <= '0;
						d2_q <= '0;
						y1_q <= '0;
						y2_q <= '0;
					end
				end
				ST_S4: begin
					if (tdf2) begin
						d1_q <= acc_sat;
					end
				end
				ST_S5: begin
					if (tdf2) begin
						d2_q <= acc_sat;
						y1_q <= y_q;
					end else begin
						d2_q <= ACC_BITS'(x1);
						d1_q <= ACC_BITS'(x_q);
						y2_q <= y1_q;
						y1_q <= y_sat;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign filtered = filtered_q;
	assign clipped  = clipped_q;

endmodule

@@ rtl/biquad_iir_section.sv @@
// Second-order IIR section with a choice of direct form 1 or transposed direct
// form 2, selected by the form register. Each input word carries one
// signed sample and a restart bit that clears all delay state before the sample
// is used; each input word yields exactly one output word with the filtered
// sample, rounded half up and saturated to the sample width, plus a clip flag
// that is set whenever saturation took place. Coefficients are signed 32-bit
// Q3.29 values (b0 resets to 1.0, the rest to zero, so the block passes samples
// through after reset); feedback coefficients a1 and a2 are subtracted. The
// transposed form keeps two 48-bit accumulators, clamped silently. Write the
// configuration registers only while no sample is in flight. All five
// products go through a single signed 32 x SAMPLE_BITS multiplier, one per
// cycle, and the word reaches the output register in step S5, after steps S1
// to S4. A new sample is accepted as soon as the previous one has left the
// multiplier sequence, even if its result word is still waiting downstream;
// the sequence only holds in its last step while the output register is
// occupied and not being read.
module biquad_iir_section #(
	parameter int SAMPLE_BITS    = biq_pkg::SAMPLE_BITS_DEF,
	parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	biq_in_if.sink                           samples,
	biq_out_if.source                        results,
	input  logic                             cfg_we,
	input  logic [biq_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [biq_pkg::COEF_BITS-1:0]    cfg_data
);
	import biq_pkg::*;

	cfg_t cfg;
	cmd_t cmd;

	// configuration register file
	biq_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// sequencer: walks the six steps and owns the output valid
	biq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	// shared multiplier, accumulator, delay state and output register
	biq_datapath #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.in_sample  (samples.sample),
		.in_restart (samples.restart),
		.filtered   (results.filtered),
		.clipped    (results.clipped)
	);

endmodule

@@ dv/biquad_tb_pkg.sv @@
`timescale 1ns / 1ps

package biquad_tb_pkg;
	import biq_pkg::*;

	localparam int SMP_BITS  = SAMPLE_BITS_DEF;
	localparam int FRAC_BITS = COEF_FRAC_BITS_DEF;
	localparam int ACC_ROOM  = ACC_BITS - SMP_BITS - 3;
	localparam int ACC_FRAC  = (FRAC_BITS < ACC_ROOM) ? FRAC_BITS : ACC_ROOM;
	localparam int ACC_DROP  = FRAC_BITS - ACC_FRAC;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic signed [SMP_BITS-1:0] filtered;
		logic                       clipped;
	} out_word_t;

	// add half an LSB, then floor
	function automatic longint round_half_up(input longint v, input int s);
		if (s == 0)
			return v;
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp_signed(input longint v, input int bits, output logic hit);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		hit = 1'b0;
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		return v;
	endfunction

	class biquad_checker;
		cfg_t                        cfg;
		logic signed [ACC_BITS-1:0]  delay_one;
		logic signed [ACC_BITS-1:0]  delay_two;
		logic signed [SMP_BITS-1:0]  past_out_one;
		logic signed [SMP_BITS-1:0]  past_out_two;
		out_word_t                   filtered_due[$];
		int                          mismatches;
		int                          samples_seen;
		int                          outputs_seen;

		function new();
			cfg.b0 = B0_RESET;
			cfg.b1 = '0;
			cfg.b2 = '0;
			cfg.a1 = '0;
			cfg.a2 = '0;
			cfg.form = FORM_DF1;
			clear_delays();
			mismatches = 0;
			samples_seen = 0;
			outputs_seen = 0;
		endfunction

		function void clear_delays();
			delay_one = '0;
			delay_two = '0;
			past_out_one = '0;
			past_out_two = '0;
		endfunction

		function void apply_config(input logic [REG_IDX_BITS-1:0] idx,
				input logic [COEF_BITS-1:0] data);
			case (idx)
				REG_B0:   cfg.b0 = data;
				REG_B1:   cfg.b1 = data;
				REG_B2:   cfg.b2 = data;
				REG_A1:   cfg.a1 = data;
				REG_A2:   cfg.a2 = data;
				REG_FORM: cfg.form = data[0];
				default: ;
			endcase
		endfunction

		// advance the filter state by one accepted sample and queue its output
		function void filter_sample(input logic signed [SMP_BITS-1:0] s, input logic r);
			longint    b0, b1, b2, a1, a2;
			longint    x, x1, x2, acc, y, n1, n2, s1, t;
			logic      clip;
			logic      acc_hit;
			out_word_t w;
			b0 = longint'($signed(cfg.b0));
			b1 = longint'($signed(cfg.b1));
			b2 = longint'($signed(cfg.b2));
			a1 = longint'($signed(cfg.a1));
			a2 = longint'($signed(cfg.a2));
			x = longint'(s);
			samples_seen++;
			if (r)
				clear_delays();
			if (cfg.form == FORM_DF1) begin
				x1 = longint'($signed(delay_one[SMP_BITS-1:0]));
				x2 = longint'($signed(delay_two[SMP_BITS-1:0]));
				acc = b0 * x + b1 * x1 + b2 * x2
					- a1 * longint'(past_out_one) - a2 * longint'(past_out_two);
				y = clamp_signed(round_half_up(acc, FRAC_BITS), SMP_BITS, clip);
				delay_two = x1[ACC_BITS-1:0];
				delay_one = x[ACC_BITS-1:0];
				past_out_two = past_out_one;
				past_out_one = y[SMP_BITS-1:0];
			end else begin
				acc = b0 * x + (longint'(delay_one) <<< ACC_DROP);
				y = clamp_signed(round_half_up(acc, FRAC_BITS), SMP_BITS, clip);
				n1 = b1 * x - a1 * y;
				n2 = b2 * x - a2 * y;
				s1 = round_half_up(n1, ACC_DROP) + longint'(delay_two);
				t = clamp_signed(s1, ACC_BITS, acc_hit);
				delay_one = t[ACC_BITS-1:0];
				t = clamp_signed(round_half_up(n2, ACC_DROP), ACC_BITS, acc_hit);
				delay_two = t[ACC_BITS-1:0];
				past_out_one = y[SMP_BITS-1:0];
			end
			w.filtered = y[SMP_BITS-1:0];
			w.clipped = clip;
			filtered_due.push_back(w);
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			if (mismatches <= MAX_PRINTED)
				$display("mismatch: %s", msg);
		endtask

		task check_output(input logic signed [SMP_BITS-1:0] f, input logic c);
			out_word_t want;
			outputs_seen++;
			if (filtered_due.size() == 0) begin
				report_mismatch($sformatf("output word %0d clip %0b with none expected", f, c));
				return;
			end
			want = filtered_due.pop_front();
			if (f !== want.filtered)
				report_mismatch($sformatf("output %0d: filtered %0d, want %0d",
					outputs_seen, f, want.filtered));
			if (c !== want.clipped)
				report_mismatch($sformatf("output %0d: clipped %0b, want %0b",
					outputs_seen, c, want.clipped));
		endtask

		task check_leftovers();
			if (filtered_due.size() != 0)
				report_mismatch($sformatf("%0d expected output words never came",
					filtered_due.size()));
		endtask

		function int pending();
			return filtered_due.size();
		endfunction
	endclass

endpackage

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the biquad section. Samples go in through the input
// channel with random gaps, results come back through the output channel with
// random back-pressure, and every output word is compared against a predictor
// that keeps its own copy of the coefficients and the delay line. Coefficients
// and the form are rewritten only between blocks of samples, once the block
// has drained.
module testbench;
	import biq_pkg::*;
	import biquad_tb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_ITEMS = 850;

	// Q3.29 coefficient landmarks
	localparam logic [COEF_BITS-1:0] COEF_ONE  = 32'h2000_0000;
	localparam logic [COEF_BITS-1:0] COEF_HALF = 32'h1000_0000;
	localparam logic [COEF_BITS-1:0] COEF_MAX  = 32'h7fff_ffff;
	localparam logic [COEF_BITS-1:0] COEF_MIN  = 32'h8000_0000;
	localparam logic [COEF_BITS-1:0] COEF_ZERO = 32'h0000_0000;
	localparam logic [COEF_BITS-1:0] EXTREME_COEFS [4] = '{
		COEF_MAX, COEF_MIN, COEF_ZERO, COEF_ONE
	};
	// a1 of about -1.8 and a2 of about 0.85: a stable, ringing low-pass
	localparam int A1_RESONANT = -966367642;
	localparam int A2_RESONANT = 456340275;

	localparam logic signed [SMP_BITS-1:0] SMP_MAX = 24'sh7f_ffff;
	localparam logic signed [SMP_BITS-1:0] SMP_MIN = 24'sh80_0000;
	localparam logic signed [SMP_BITS-1:0] EXTREME_SAMPLES [5] = '{
		SMP_MAX, SMP_MIN, 24'sd0, 24'sd1, -24'sd1
	};

	// the form register only looks at bit 0; the index past the last
	// register must be ignored
	localparam logic [COEF_BITS-1:0] FORM_DF1_NOISY = 32'hffff_fffe;
	localparam logic [REG_IDX_BITS-1:0] REG_UNMAPPED = REG_IDX_BITS'(NUM_REGS);

	typedef enum int {
		SET_TAME,
		SET_WILD,
		SET_EXTREME,
		SET_RESONANT
	} setting_kind_t;

	typedef enum int {
		SMP_FULL,
		SMP_SMALL,
		SMP_EXTREME
	} sample_kind_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [REG_IDX_BITS-1:0]  cfg_index;
	logic [COEF_BITS-1:0]     cfg_data;

	biq_in_if  samples_if ();
	biq_out_if results_if ();

	biquad_iir_section dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_if),
		.results   (results_if),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	biquad_checker sb;

	int  send_idle_pct;
	int  recv_idle_pct;
	bit  hold_off;
	bit  stall_go;
	int  cycle_count;
	int  settings_used;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Watchdog: end the run if the drain never completes.
	always @(posedge clk) begin
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding",
				cycle_count, sb.pending());
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			cycle_count <= cycle_count + 1;
		end
	end

	// Receiver side: drop ready at random, or for the whole of a hold-off.
	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			results_if.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Hold off the receiver for a long stretch once the last phase starts, so
	// the output register stays full and the block stops taking samples.
	initial begin
		hold_off = 1'b0;
		wait (stall_go);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 1'b0;
	end

	// Compare every word that leaves the block.
	always @(posedge clk) begin
		if (arst_n && results_if.valid && results_if.ready)
			sb.check_output(results_if.filtered, results_if.clipped);
	end

	// Write one register; the predictor takes it at the same edge.
	task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
			input logic [COEF_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.apply_config(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Offer one word after a random gap and hold it until accepted. Valid is
	// left high afterwards so back-to-back words need no bubble.
	task automatic send_word(input logic signed [SMP_BITS-1:0] s, input logic r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			samples_if.sample <= SMP_BITS'($urandom);
			samples_if.restart <= 1'($urandom);
			@(negedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.sample <= s;
		samples_if.restart <= r;
		@(posedge clk);
		while (!samples_if.ready) @(posedge clk);
		sb.filter_sample(s, r);
	endtask

	// Drop valid and wait until every queued output word has been checked.
	task automatic finish_block();
		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// One block of random samples under a freshly drawn setting.
	task automatic run_random_block(input int count);
		setting_kind_t              kind;
		sample_kind_t               skind;
		logic signed [SMP_BITS-1:0] s;
		logic                       r;
		kind = setting_kind_t'($urandom_range(3));
		case (kind)
			SET_TAME: begin
				// all coefficients within +-1.0
				write_reg(REG_B0, 32'($urandom_range(32'h4000_0000)) - COEF_ONE);
				write_reg(REG_B1, 32'($urandom_range(32'h4000_0000)) - COEF_ONE);
				write_reg(REG_B2, 32'($urandom_range(32'h4000_0000)) - COEF_ONE);
				write_reg(REG_A1, 32'($urandom_range(32'h4000_0000)) - COEF_ONE);
				write_reg(REG_A2, 32'($urandom_range(32'h4000_0000)) - COEF_ONE);
			end
			SET_WILD: begin
				write_reg(REG_B0, $urandom);
				write_reg(REG_B1, $urandom);
				write_reg(REG_B2, $urandom);
				write_reg(REG_A1, $urandom);
				write_reg(REG_A2, $urandom);
			end
			SET_EXTREME: begin
				write_reg(REG_B0, EXTREME_COEFS[$urandom_range(3)]);
				write_reg(REG_B1, EXTREME_COEFS[$urandom_range(3)]);
				write_reg(REG_B2, EXTREME_COEFS[$urandom_range(3)]);
				write_reg(REG_A1, EXTREME_COEFS[$urandom_range(3)]);
				write_reg(REG_A2, EXTREME_COEFS[$urandom_range(3)]);
			end
			default: begin
				// narrow low-pass: small feedforward, 1-2-1 shape, jittered poles
				s = SMP_BITS'($urandom_range(32'h40_0000));
				write_reg(REG_B0, 32'(s));
				write_reg(REG_B1, 32'(s) << 1);
				write_reg(REG_B2, 32'(s));
				write_reg(REG_A1, 32'(A1_RESONANT + int'($urandom_range(2097152)) - 1048576));
				write_reg(REG_A2, 32'(A2_RESONANT + int'($urandom_range(2097152)) - 1048576));
			end
		endcase
		// full random word: the form register must ignore the upper bits
		write_reg(REG_FORM, $urandom);
		settings_used++;

		for (int i = 0; i < count; i++) begin
			skind = sample_kind_t'($urandom_range(2));
			case (skind)
				SMP_FULL:  s = SMP_BITS'($urandom);
				SMP_SMALL: s = SMP_BITS'(int'($urandom_range(2000)) - 1000);
				default:   s = EXTREME_SAMPLES[$urandom_range(4)];
			endcase
			// restart the first word of a block half the time, then rarely
			if (i == 0)
				r = 1'($urandom_range(1));
			else
				r = ($urandom_range(19) == 0);
			send_word(s, r);
		end
		finish_block();
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input int items);
		int done;
		int n;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		done = 0;
		while (done < items) begin
			n = $urandom_range(50, 15);
			run_random_block(n);
			done += n;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		samples_if.restart = 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 82;
		stall_go = 1'b0;
		cycle_count = 0;
		settings_used = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Out of reset the section is a unity pass-through: check the full
		// scale ends and a restart on an otherwise quiet filter.
		send_word(SMP_MAX, 1'b0);
		send_word(SMP_MIN, 1'b0);
		send_word(24'sd0, 1'b0);
		send_word(-24'sd1, 1'b1);
		send_word(24'sd1, 1'b0);
		finish_block();
		settings_used++;

		// Gain of one half lands exactly on half an LSB: rounding goes up,
		// so -0.5 becomes 0 and -1.5 becomes -1.
		write_reg(REG_B0, COEF_HALF);
		send_word(24'sd1, 1'b0);
		send_word(-24'sd1, 1'b0);
		send_word(24'sd3, 1'b0);
		send_word(-24'sd3, 1'b0);
		finish_block();
		settings_used++;

		// Full-scale coefficients of both signs: the output clips both ways
		// and the clipped value feeds back.
		write_reg(REG_B0, COEF_MAX);
		write_reg(REG_B1, COEF_MIN);
		write_reg(REG_B2, COEF_MAX);
		write_reg(REG_A1, COEF_MAX);
		write_reg(REG_A2, COEF_MIN);
		write_reg(REG_UNMAPPED, COEF_ZERO);
		write_reg(REG_FORM, FORM_DF1_NOISY);
		send_word(SMP_MAX, 1'b0);
		send_word(SMP_MIN, 1'b0);
		send_word(SMP_MAX, 1'b0);
		send_word(24'sd12345, 1'b0);
		finish_block();
		settings_used++;

		// Switch to the transposed form without a restart, so the stored past
		// inputs are read as accumulators; push the accumulators into clamping.
		write_reg(REG_FORM, 32'(FORM_TDF2));
		write_reg(REG_B1, COEF_MAX);
		write_reg(REG_A1, COEF_MIN);
		write_reg(REG_B2, COEF_MIN);
		write_reg(REG_A2, COEF_MAX);
		send_word(SMP_MAX, 1'b0);
		send_word(SMP_MAX, 1'b0);
		send_word(SMP_MIN, 1'b0);
		send_word(24'sd7, 1'b1);
		send_word(SMP_MIN, 1'b0);
		finish_block();
		settings_used++;

		// Back to direct form, again without a restart: the accumulators are
		// read through their low bits and the second past output is stale,
		// since the transposed form never updates it.
		write_reg(REG_FORM, 32'(FORM_DF1));
		write_reg(REG_B0, COEF_ONE);
		send_word(24'sd100, 1'b0);
		send_word(-24'sd100, 1'b0);
		send_word(24'sd0, 1'b0);
		finish_block();
		settings_used++;

		run_phase(17, 82, RANDOM_ITEMS / 3);
		run_phase(82, 17, RANDOM_ITEMS / 3);
		stall_go = 1'b1;
		run_phase(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

		repeat (TAIL_CYCLES) @(posedge clk);
		sb.check_leftovers();
		$display("fed %0d samples through %0d settings of both forms, including a %0d-cycle stall",
			sb.samples_seen, settings_used, HOLD_CYCLES);
		$display("checked %0d output words, %0d mismatches", sb.outputs_seen, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
